// ===== src/int_to_radix_ascii_assert.svh =====
// Assertion macros shared by the integer to radix ASCII converter modules.
`ifndef INT_TO_RADIX_ASCII_ASSERT_SVH
`define INT_TO_RADIX_ASCII_ASSERT_SVH

`ifndef SYNTHESIS
`define ITRA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ITRA_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `ITRA_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define ITRA_ASSERT(lbl, clk, rstn, prop, msg)
`define ITRA_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== src/itra_pkg.sv =====
// Shared constants, types and helpers of the integer to radix ASCII converter.
`default_nettype none

package itra_pkg;

  localparam int VALUE_BITS     = 31;
  localparam int RADIX_BITS     = 5;
  localparam int DIGIT_BITS     = 4;
  localparam int CHAR_BITS      = 7;
  localparam int COUNT_BITS     = 6;
  localparam int DIGIT_SLOTS    = 32;
  localparam int SLOT_IDX_BITS  = $clog2(DIGIT_SLOTS);

  localparam int STEP_BITS      = 8;
  localparam int WORK_BITS      = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int CHUNKS         = WORK_BITS / STEP_BITS;
  localparam int CHUNK_CNT_BITS = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  localparam int RADIX_MIN      = 2;
  localparam int RADIX_MAX      = 16;

  localparam int S_DATA_BITS    = ((VALUE_BITS + RADIX_BITS + 7) / 8) * 8;
  localparam int M_DATA_BITS    = ((CHAR_BITS + 7) / 8) * 8;

  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_BITS      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

  localparam int ASCII_ZERO     = 48;
  localparam int ASCII_UPPER_A  = 65;
  localparam int DEC_MAX        = 9;
  localparam int DEC_BASE       = 10;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_BITS-1:0] radix;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } back_state_e;

  function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] c;
    if (d <= DIGIT_BITS'(DEC_MAX)) begin
      c = CHAR_BITS'(ASCII_ZERO) + CHAR_BITS'(d);
    end else begin
      c = CHAR_BITS'(ASCII_UPPER_A) + CHAR_BITS'(d) - CHAR_BITS'(DEC_BASE);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/itra_front.sv =====
// Input side: accepts transactions, drops unusable ones and queues the rest.
`default_nettype none
`include "int_to_radix_ascii_assert.svh"

module itra_front
  import itra_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [S_DATA_BITS-1:0] s_axis_tdata_i,  // value, radix
  output logic                        job_valid_o,
  input  wire logic                   job_ready_i,
  output job_t                        job_o
);

  job_t                 queue_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0] cnt_q, cnt_d;
  job_t                 in_job;
  logic                 keep;
  logic                 accept;
  logic                 push;
  logic                 pop;

  assign in_job.value = s_axis_tdata_i[VALUE_BITS-1:0];
  assign in_job.radix = s_axis_tdata_i[VALUE_BITS +: RADIX_BITS];

  assign keep = (in_job.radix inside {[RADIX_MIN:RADIX_MAX]}) && (in_job.value != '0);

  assign s_axis_tready_o = (cnt_q != QCNT_BITS'(QUEUE_DEPTH));
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign push            = accept && keep;
  assign job_valid_o     = (cnt_q != '0);
  assign pop             = job_valid_o && job_ready_i;
  assign job_o           = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= in_job;
    end
  end

  `ITRA_ASSERT(a_queue_bound, clk_i, rst_ni, cnt_q <= QCNT_BITS'(QUEUE_DEPTH), "queue overfilled")
  `ITRA_ASSERT(a_drop_keeps_count, clk_i, rst_ni, (accept && !keep && !pop) |=> $stable(cnt_q), "dropped transaction changed the queue")
  `ITRA_ASSERT(a_push_counts, clk_i, rst_ni, (push && !pop) |=> (cnt_q == QCNT_BITS'($past(cnt_q) + 1'b1)), "push not counted")
  `ITRA_ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, pop && (cnt_q == '0), "pop from empty queue")

endmodule

`default_nettype wire

// ===== src/itra_back.sv =====
// Conversion side: divides by the radix digit by digit, then sends the characters.
`default_nettype none
`include "int_to_radix_ascii_assert.svh"

module itra_back
  import itra_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   job_valid_i,
  output logic                        job_ready_o,
  input  wire job_t                   job_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [M_DATA_BITS-1:0]      m_axis_tdata_o,  // digit_char
  output logic                        m_axis_tlast_o   // last
);

  back_state_e               state_q, state_d;
  logic [WORK_BITS-1:0]      work_q, work_d;
  logic [DIGIT_BITS-1:0]     rem_q, rem_d;
  logic [RADIX_BITS-1:0]     radix_q, radix_d;
  logic [CHUNK_CNT_BITS-1:0] chunk_q, chunk_d;
  logic [COUNT_BITS-1:0]     count_q, count_d;
  logic [SLOT_IDX_BITS-1:0]  ptr_q, ptr_d;
  logic [DIGIT_BITS-1:0]     store_q [DIGIT_SLOTS];
  logic                      out_valid_q, out_valid_d;
  logic [CHAR_BITS-1:0]      out_char_q, out_char_d;
  logic                      out_last_q, out_last_d;
  logic [WORK_BITS-1:0]      step_work;
  logic [DIGIT_BITS-1:0]     step_rem;
  logic                      digit_done;
  logic                      store_we;
  logic                      out_load;
  logic                      has_room;

  always_comb begin
    logic [RADIX_BITS-1:0] cand;
    step_work = work_q;
    step_rem  = rem_q;
    for (int i = 0; i < STEP_BITS; i++) begin
      cand      = RADIX_BITS'({step_rem, step_work[WORK_BITS-1]});
      step_work = {step_work[WORK_BITS-2:0], 1'b0};
      if (cand >= radix_q) begin
        step_rem     = DIGIT_BITS'(cand - radix_q);
        step_work[0] = 1'b1;
      end else begin
        step_rem = DIGIT_BITS'(cand);
      end
    end
  end

  assign digit_done = (state_q == ST_DIVIDE) && (chunk_q == CHUNK_CNT_BITS'(CHUNKS - 1));
  assign has_room   = (count_q < COUNT_BITS'(DIGIT_SLOTS));
  assign store_we   = digit_done && has_room;
  assign out_load   = !out_valid_q || m_axis_tready_i;
  assign job_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    work_d      = work_q;
    rem_d       = rem_q;
    radix_d     = radix_q;
    chunk_d     = chunk_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          work_d  = WORK_BITS'(job_i.value);
          rem_d   = '0;
          radix_d = job_i.radix;
          chunk_d = '0;
          count_d = '0;
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        work_d  = step_work;
        rem_d   = step_rem;
        chunk_d = chunk_q + 1'b1;
        if (digit_done) begin
          rem_d   = '0;
          chunk_d = '0;
          if (has_room) begin
            count_d = count_q + 1'b1;
          end
          if (step_work == '0) begin
            ptr_d   = has_room ? count_q[SLOT_IDX_BITS-1:0]
                               : SLOT_IDX_BITS'(DIGIT_SLOTS - 1);
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_char_d  = digit_to_ascii(store_q[ptr_q]);
          out_last_d  = (ptr_q == '0);
          if (ptr_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            ptr_d = ptr_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chunk_q     <= '0;
      count_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chunk_q     <= chunk_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q     <= work_d;
    rem_q      <= rem_d;
    radix_q    <= radix_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    if (store_we) begin
      store_q[count_q[SLOT_IDX_BITS-1:0]] <= step_rem;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = M_DATA_BITS'(out_char_q);
  assign m_axis_tlast_o  = out_last_q;

  `ITRA_ASSERT(a_rem_below_radix, clk_i, rst_ni, (state_q == ST_DIVIDE) |-> (RADIX_BITS'(rem_q) < radix_q), "remainder not below radix")
  `ITRA_ASSERT(a_emit_has_digits, clk_i, rst_ni, (state_q == ST_EMIT) |-> (count_q != '0), "emitting without digits")
  `ITRA_ASSERT(a_last_ends_run, clk_i, rst_ni, (state_q == ST_EMIT && out_load && ptr_q == '0) |=> (state_q == ST_IDLE && m_axis_tlast_o), "final character did not close the run")

endmodule

`default_nettype wire

// ===== src/int_to_radix_ascii.sv =====
// Top level of the integer to radix ASCII converter.
// Accepted transactions wait in a two-entry queue; the converter takes one job at a time,
// divides it by the radix with the 8-bit-per-cycle divider until the quotient is zero, and
// then sends its characters most significant first, one per cycle while the output accepts.
// The queue lets the input side keep accepting while a job is converted.
// Reset clears the queue, the converter state and the output valid flag.
`default_nettype none

module int_to_radix_ascii
  import itra_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [S_DATA_BITS-1:0] s_axis_tdata_i,  // value, radix
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [M_DATA_BITS-1:0]      m_axis_tdata_o,  // digit_char
  output logic                        m_axis_tlast_o   // last
);

  logic job_valid;
  logic job_ready;
  job_t job;

  itra_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .job_valid_o     (job_valid),
    .job_ready_i     (job_ready),
    .job_o           (job)
  );

  itra_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (job_valid),
    .job_ready_o     (job_ready),
    .job_i           (job),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

// ===== tb/int_to_radix_ascii_test.sv =====
// Self-checking testbench for the integer to radix ASCII converter.
`timescale 1ns / 100ps

module int_to_radix_ascii_test;
  import itra_pkg::*;

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_BITS-1:0] radix;
    bit                    hold_for_clear;
  } pending_job_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] digit_char;
    logic                 last;
  } char_exp_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [S_DATA_BITS-1:0] s_axis_tdata_i = '0;  // value, radix
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [M_DATA_BITS-1:0] m_axis_tdata_o;  // digit_char
  logic                   m_axis_tlast_o;  // last

  pending_job_t pending_jobs[$];
  char_exp_t    expected_chars[$];

  logic [DIGIT_BITS-1:0] digit_store[DIGIT_SLOTS];
  logic [COUNT_BITS-1:0] digit_count = '0;

  int send_idle_pct = 6;
  int recv_idle_pct = 83;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int error_count = 0;

  int_to_radix_ascii i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #6 clk_i = ~clk_i;

  // Divides the value down to its remainders and queues the characters they
  // turn into, most significant digit first.
  function automatic void predict_chars(input logic [VALUE_BITS-1:0] value,
                                        input logic [RADIX_BITS-1:0] radix);
    logic [VALUE_BITS-1:0] rest;
    logic [DIGIT_BITS-1:0] digit;
    char_exp_t             exp_char;
    int                    n;
    rest = value;
    n = 0;
    if (radix < RADIX_MIN || radix > RADIX_MAX) begin
      digit_count = '0;
      return;
    end
    while (rest != '0) begin
      if (n < DIGIT_SLOTS) begin
        digit_store[n] = DIGIT_BITS'(rest % radix);
        n++;
      end
      rest = rest / radix;
    end
    digit_count = COUNT_BITS'(n);
    for (int k = n - 1; k >= 0; k--) begin
      digit = digit_store[k];
      if (digit <= DEC_MAX) begin
        exp_char.digit_char = CHAR_BITS'(ASCII_ZERO + digit);
      end else begin
        exp_char.digit_char = CHAR_BITS'(ASCII_UPPER_A + digit - DEC_BASE);
      end
      exp_char.last = (k == 0);
      expected_chars.push_back(exp_char);
    end
  endfunction

  task automatic queue_job(input logic [VALUE_BITS-1:0] value,
                           input logic [RADIX_BITS-1:0] radix,
                           input bit hold_for_clear = 1'b0);
    pending_job_t job;
    job.value = value;
    job.radix = radix;
    job.hold_for_clear = hold_for_clear;
    pending_jobs.push_back(job);
  endtask

  // Mostly short values in legal radixes, with some full-width values,
  // zero values and out-of-range radixes mixed in.
  task automatic queue_random_jobs(input int count);
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_BITS-1:0] radix;
    int                    width;
    int                    converted;
    converted = 0;
    while (converted < count) begin
      width = ($urandom_range(3) == 0) ? VALUE_BITS : $urandom_range(1, 12);
      value = VALUE_BITS'($urandom) >> (VALUE_BITS - width);
      if ($urandom_range(99) < 85) begin
        radix = RADIX_BITS'($urandom_range(RADIX_MIN, RADIX_MAX));
      end else begin
        radix = RADIX_BITS'($urandom_range(0, (1 << RADIX_BITS) - 1));
      end
      queue_job(value, radix, converted == count / 2 && $urandom_range(1) == 1);
      if (value != '0 && radix >= RADIX_MIN && radix <= RADIX_MAX) begin
        converted++;
      end
    end
  endtask

  task automatic wait_all_done();
    while (pending_jobs.size() != 0 || s_axis_tvalid_i || expected_chars.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (300) @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    pending_job_t job;
    logic         offer;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i <= '0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (s_axis_tvalid_i) begin
        predict_chars(s_axis_tdata_i[VALUE_BITS-1:0], s_axis_tdata_i[VALUE_BITS +: RADIX_BITS]);
      end
      offer = pending_jobs.size() != 0 && $urandom_range(99) >= send_idle_pct;
      if (offer && pending_jobs[0].hold_for_clear && expected_chars.size() != 0) begin
        offer = 1'b0;
      end
      if (offer) begin
        job = pending_jobs.pop_front();
        s_axis_tdata_i <= S_DATA_BITS'({job.radix, job.value});
      end
      s_axis_tvalid_i <= offer;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      hold_left <= 0;
    end else if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= 400;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  always @(posedge clk_i) begin : check_proc
    char_exp_t exp_char;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected transaction: digit_char %0d last %0b",
               m_axis_tdata_o[CHAR_BITS-1:0], m_axis_tlast_o);
        error_count++;
      end else begin
        exp_char = expected_chars.pop_front();
        if (m_axis_tdata_o[CHAR_BITS-1:0] !== exp_char.digit_char) begin
          $error("digit_char: expected %0d, actual %0d",
                 exp_char.digit_char, m_axis_tdata_o[CHAR_BITS-1:0]);
          error_count++;
        end
        if (m_axis_tlast_o !== exp_char.last) begin
          $error("last: expected %0b, actual %0b", exp_char.last, m_axis_tlast_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    #12_000_000;
    $display("int_to_radix_ascii_test: done, errors");
    $finish;
  end

  initial begin
    for (int i = 0; i < DIGIT_SLOTS; i++) begin
      digit_store[i] = '0;
    end

    queue_job(VALUE_BITS'(1), RADIX_BITS'(2));
    queue_job('1, RADIX_BITS'(2));
    queue_job('1, RADIX_BITS'(3));
    queue_job('1, RADIX_BITS'(10));
    queue_job('1, RADIX_BITS'(16));
    queue_job(VALUE_BITS'(32'h2AAA_AAAA), RADIX_BITS'(7));
    queue_job(VALUE_BITS'(32'h5555_5555), RADIX_BITS'(13));
    queue_job(VALUE_BITS'(32'h00AB_CDEF), RADIX_BITS'(16));
    queue_job(VALUE_BITS'(15), RADIX_BITS'(16));
    queue_job(VALUE_BITS'(10), RADIX_BITS'(11));
    queue_job(VALUE_BITS'(9), RADIX_BITS'(10));
    queue_job(VALUE_BITS'(16), RADIX_BITS'(16));
    queue_job('0, RADIX_BITS'(10));
    queue_job(VALUE_BITS'(12345), RADIX_BITS'(0));
    queue_job(VALUE_BITS'(12345), RADIX_BITS'(1));
    queue_job(VALUE_BITS'(12345), RADIX_BITS'(17));
    queue_job('1, '1);
    queue_job(VALUE_BITS'(999), RADIX_BITS'(4));
    queue_job(VALUE_BITS'(999), RADIX_BITS'(5));
    queue_job(VALUE_BITS'(999), RADIX_BITS'(6));
    queue_job(VALUE_BITS'(999), RADIX_BITS'(8));
    queue_job(VALUE_BITS'(999), RADIX_BITS'(9));
    queue_job(VALUE_BITS'(999), RADIX_BITS'(12));
    queue_job(VALUE_BITS'(999), RADIX_BITS'(14));
    queue_job(VALUE_BITS'(999), RADIX_BITS'(15), 1'b1);
    queue_random_jobs(40);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait_all_done();

    @(negedge clk_i);
    send_idle_pct = 83;
    recv_idle_pct = 6;
    queue_random_jobs(40);
    wait_all_done();

    @(negedge clk_i);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    queue_random_jobs(40);
    wait_all_done();

    if (error_count == 0) begin
      $display("int_to_radix_ascii_test: done, clean");
    end else begin
      $display("int_to_radix_ascii_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/itra_pkg.sv
src/itra_front.sv
src/itra_back.sv
src/int_to_radix_ascii.sv
tb/int_to_radix_ascii_test.sv
